// ===== rtl/core/selt_pkg.sv =====
package selt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_BITS     = 16;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);
	localparam int COUNT_BITS  = 7;

	localparam logic [2:0] ACT_ACQUIRE   = 3'd0;
	localparam logic [2:0] ACT_RELEASE   = 3'd1;
	localparam logic [2:0] ACT_REL_OWNER = 3'd2;
	localparam logic [2:0] ACT_QUERY     = 3'd3;
	localparam logic [2:0] ACT_COUNT     = 3'd4;

	localparam logic [2:0] ST_GRANTED   = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_CONFLICT  = 3'd3;
	localparam logic [2:0] ST_RELEASED  = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;
	localparam logic [2:0] ST_DONE      = 3'd7;

	typedef struct packed {
		logic [ID_BITS-1:0] lease;
		logic [ID_BITS-1:0] owner;
		logic [ID_BITS-1:0] resource;
		logic               excl;
		logic               active;
	} entry_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [ID_BITS-1:0] lease_id;
		logic [ID_BITS-1:0] owner_id;
		logic [ID_BITS-1:0] resource_id;
		logic               exclusive;
		logic               ids_valid;
	} op_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [COUNT_BITS-1:0] count;
		logic                  lease_active;
	} result_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		entry_t        wdata;
		logic [AW-1:0] raddr;
	} ram_cmd_t;

	// low bits of a table-sized count, zero-extended when the count is narrow
	function automatic logic [COUNT_BITS-1:0] to_count(input logic [CW-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[COUNT_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/selt_req_if.sv =====
interface selt_req_if;
	import selt_pkg::*;

	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [ID_BITS-1:0] lease_id;
	logic [ID_BITS-1:0] owner_id;
	logic [ID_BITS-1:0] resource_id;
	logic               exclusive;
	logic               ids_valid;

	modport source (
		output valid, action, lease_id, owner_id, resource_id, exclusive, ids_valid,
		input  ready
	);

	modport sink (
		input  valid, action, lease_id, owner_id, resource_id, exclusive, ids_valid,
		output ready
	);

endinterface

// ===== rtl/core/selt_rsp_if.sv =====
interface selt_rsp_if;
	import selt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [COUNT_BITS-1:0] count;
	logic                  lease_active;

	modport source (
		output valid, status, count, lease_active,
		input  ready
	);

	modport sink (
		input  valid, status, count, lease_active,
		output ready
	);

endinterface

// ===== rtl/core/selt_ram.sv =====
module selt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/selt_scan.sv =====
module selt_scan (
	input  logic               clk,
	input  logic               arst_n,
	selt_req_if.sink           req,
	input  logic               slot_free,
	output selt_pkg::ram_cmd_t ram_cmd,
	input  selt_pkg::entry_t   rdata,
	output logic               res_valid,
	output selt_pkg::result_t  res
);
	import selt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	op_t           op_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] iss_q;
	logic [CW-1:0] cnt_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic          dup_q;
	logic          conf_q;
	logic          hit_q;

	logic take;
	logic issue;
	logic lease_m;
	logic res_m;
	logic rel_wr;
	logic own_wr;
	logic acq_ok;

	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign issue     = (iss_q < fill_q);

	// entry idx_s1 is on the read port while the scan runs
	assign lease_m = v_s1 && (rdata.lease == op_q.lease_id);
	assign res_m   = v_s1 && rdata.active && (rdata.resource == op_q.resource_id)
		&& (op_q.exclusive || rdata.excl);
	assign rel_wr  = (state_q == S_SCAN) && (op_q.action == ACT_RELEASE)
		&& lease_m && rdata.active;
	assign own_wr  = (state_q == S_SCAN) && (op_q.action == ACT_REL_OWNER)
		&& op_q.ids_valid && v_s1 && rdata.active && (rdata.owner == op_q.owner_id);
	assign acq_ok  = (op_q.action == ACT_ACQUIRE) && op_q.ids_valid && !dup_q && !conf_q
		&& (fill_q != CW'(TABLE_DEPTH));

	assign res_valid = (state_q == S_FIN) && slot_free;

	always_comb begin
		ram_cmd.raddr = (state_q == S_IDLE) ? '0 : iss_q[AW-1:0];
		if (state_q == S_FIN) begin
			ram_cmd.we           = res_valid && acq_ok;
			ram_cmd.waddr        = fill_q[AW-1:0];
			ram_cmd.wdata.lease    = op_q.lease_id;
			ram_cmd.wdata.owner    = op_q.owner_id;
			ram_cmd.wdata.resource = op_q.resource_id;
			ram_cmd.wdata.excl     = op_q.exclusive;
			ram_cmd.wdata.active   = 1'b1;
		end else begin
			// write-back of the entry just read, with its active bit dropped
			ram_cmd.we           = rel_wr || own_wr;
			ram_cmd.waddr        = idx_s1;
			ram_cmd.wdata        = rdata;
			ram_cmd.wdata.active = 1'b0;
		end
	end

	always_comb begin
		res.status       = ST_INVALID;
		res.count        = '0;
		res.lease_active = 1'b0;
		unique case (op_q.action)
			ACT_ACQUIRE: begin
				priority if (!op_q.ids_valid) begin
					res.status = ST_INVALID;
				end else if (dup_q) begin
					res.status = ST_DUPLICATE;
				end else if (conf_q) begin
					res.status = ST_CONFLICT;
				end else if (fill_q == CW'(TABLE_DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_GRANTED;
				end
			end
			ACT_RELEASE: begin
				res.status = hit_q ? ST_RELEASED : ST_NOT_FOUND;
			end
			ACT_REL_OWNER: begin
				if (op_q.ids_valid) begin
					res.status = ST_DONE;
					res.count  = to_count(cnt_q);
				end
			end
			ACT_QUERY: begin
				res.status       = ST_DONE;
				res.lease_active = hit_q;
			end
			ACT_COUNT: begin
				res.status = ST_DONE;
				res.count  = to_count(active_q);
			end
			default: begin
				res.status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q.action      <= req.action;
			op_q.lease_id    <= req.lease_id;
			op_q.owner_id    <= req.owner_id;
			op_q.resource_id <= req.resource_id;
			op_q.exclusive   <= req.exclusive;
			op_q.ids_valid   <= req.ids_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			active_q <= '0;
			iss_q    <= '0;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			idx_s1   <= '0;
			dup_q    <= 1'b0;
			conf_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						dup_q  <= 1'b0;
						conf_q <= 1'b0;
						hit_q  <= 1'b0;
						cnt_q  <= '0;
						iss_q  <= CW'(1);
						idx_s1 <= '0;
						v_s1   <= (fill_q != '0);
						state_q <= (req.action <= ACT_QUERY) ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					v_s1   <= issue;
					idx_s1 <= iss_q[AW-1:0];
					if (issue) begin
						iss_q <= iss_q + CW'(1);
					end
					dup_q  <= dup_q || lease_m;
					conf_q <= conf_q || res_m;
					hit_q  <= hit_q || (lease_m && rdata.active);
					if (rel_wr || own_wr) begin
						active_q <= active_q - CW'(1);
					end
					if (own_wr) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (!v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_valid) begin
						if (acq_ok) begin
							fill_q   <= fill_q + CW'(1);
							active_q <= active_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= fill_q)
		else $error("active total exceeds fill count");

	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_cmd.we && state_q == S_SCAN) |-> (v_s1 && (CW'(idx_s1) < fill_q)))
		else $error("write-back to an entry that was not read");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_cmd.we |-> (state_q == S_SCAN || state_q == S_FIN))
		else $error("table write outside scan or finish");

	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (state_q == S_IDLE))
		else $error("result issued without returning to idle");

endmodule

// ===== rtl/core/shared_exclusive_lease_table.sv =====
// channel | dir | handshake        | payload
// req     | in  | valid/ready      | action, lease_id, owner_id, resource_id, exclusive, ids_valid
// rsp     | out | valid/ready      | status, count, lease_active
//
// Each item walks every appended entry through the single read port of the lease
// table, one per cycle, between an accept step and a finish step.
// Count and unknown actions skip the walk.
// Reset clears fill count, active total and control; table contents need no clearing.
// A held result in the output register does not block acceptance; the finish step
// waits only while that register is full and rsp.ready is low.
module shared_exclusive_lease_table (
	input logic        clk,
	input logic        arst_n,
	selt_req_if.sink   req,
	selt_rsp_if.source rsp
);
	import selt_pkg::*;

	ram_cmd_t             ram_cmd;
	logic [$bits(entry_t)-1:0] rdata_raw;
	logic                 res_valid;
	result_t              res;
	logic                 slot_free;
	logic                 out_valid_q;
	result_t              out_q;

	selt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_cmd.wdata),
		.raddr (ram_cmd.raddr),
		.rdata (rdata_raw)
	);

	selt_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.slot_free (slot_free),
		.ram_cmd   (ram_cmd),
		.rdata     (entry_t'(rdata_raw)),
		.res_valid (res_valid),
		.res       (res)
	);

	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.count        = out_q.count;
	assign rsp.lease_active = out_q.lease_active;

endmodule
